FILE: src/spg_pkg.sv
// ----------------------------------------------------------------------------
// spg_pkg
// Shared types, constants and the CORDIC arctangent table of the spiral point
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package spg_pkg;

  // Datapath width of the shared CORDIC unit (vectoring needs 42 bits plus sign).
  localparam int CORDIC_W = 44;
  // Dividend width of the shared restoring divider.
  localparam int NUM_W = 64;
  // Quotient width kept by the divider; larger quotients set a sticky flag.
  localparam int QUO_W = 32;

  localparam logic [63:0] TWO_PI_Q60      = 64'h6487ED5110B4611A;
  localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
  localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;
  localparam int          RED_EXTRA       = 28;
  localparam int          MAG_GUARD       = 8;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_GROWTH  = 2'd0,
    CFG_START   = 2'd1,
    CFG_SPACING = 2'd2,
    CFG_COUNT   = 2'd3
  } cfg_idx_e;

  // atan(2^-i) in Q30; small angles use the 2^-i approximation.
  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] r;
    case (i)
      5'd0:    r = 31'd843314857;
      5'd1:    r = 31'd497837829;
      5'd2:    r = 31'd263043837;
      5'd3:    r = 31'd133525159;
      5'd4:    r = 31'd67021687;
      5'd5:    r = 31'd33543516;
      5'd6:    r = 31'd16775851;
      5'd7:    r = 31'd8388437;
      5'd8:    r = 31'd4194283;
      5'd9:    r = 31'd2097149;
      5'd31:   r = '0;
      default: r = 31'd1 << (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/spg_if.sv
// ----------------------------------------------------------------------------
// spg_in_if / spg_out_if
// Valid/ready channels for restart words in and point words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface spg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface spg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [15:0] point_index;
  logic        last_point;

  modport source (output valid, output point_x, output point_y, output point_index,
                  output last_point, input ready);
  modport sink (input valid, input point_x, input point_y, input point_index,
                input last_point, output ready);
endinterface

`default_nettype wire

FILE: src/spg_cordic.sv
// ----------------------------------------------------------------------------
// spg_cordic
// Iterative CORDIC, one micro-rotation per cycle, in rotation or vectoring mode.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_cordic #(
  parameter int STEPS = 18
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start_i,
  input  wire                                  vector_i,
  input  wire  signed [spg_pkg::CORDIC_W-1:0]  x_i,
  input  wire  signed [spg_pkg::CORDIC_W-1:0]  y_i,
  input  wire  signed [spg_pkg::CORDIC_W-1:0]  z_i,
  output logic                                 done_o,
  output logic signed [spg_pkg::CORDIC_W-1:0]  x_o,
  output logic signed [spg_pkg::CORDIC_W-1:0]  y_o
);
  import spg_pkg::*;

  localparam int IDX_W = $clog2(STEPS);

  logic                       busy_q, vector_q;
  logic [IDX_W-1:0]           i_q;
  logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
  logic signed [CORDIC_W-1:0] x_d, y_d, z_d, dx, dy, at;
  logic                       pos;

  // One micro-rotation; the direction follows z in rotation and y in vectoring.
  always_comb begin
    dx  = y_q >>> i_q;
    dy  = x_q >>> i_q;
    at  = $signed(CORDIC_W'(atan_q30(5'(i_q))));
    pos = vector_q ? y_q[CORDIC_W-1] : !z_q[CORDIC_W-1];
    if (pos) begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - at;
    end else begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_o   <= 1'b0;
      i_q      <= '0;
      vector_q <= 1'b0;
      x_q      <= '0;
      y_q      <= '0;
      z_q      <= '0;
    end else begin
      done_o <= !start_i && busy_q && (i_q == IDX_W'(STEPS - 1));
      if (start_i) begin
        busy_q   <= 1'b1;
        i_q      <= '0;
        vector_q <= vector_i;
        x_q      <= x_i;
        y_q      <= y_i;
        z_q      <= z_i;
      end else if (busy_q) begin
        x_q <= x_d;
        y_q <= y_d;
        z_q <= z_d;
        i_q <= i_q + 1'b1;
        if (i_q == IDX_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

`default_nettype wire

FILE: src/spg_divider.sv
// ----------------------------------------------------------------------------
// spg_divider
// Restoring divider, one quotient bit per cycle over a 64-bit dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_divider #(
  parameter int DW = 48
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire  [spg_pkg::NUM_W-1:0]    num_i,
  input  wire  [DW-1:0]                den_i,
  output logic                         done_o,
  output logic [spg_pkg::QUO_W-1:0]    quo_o,
  output logic                         ovf_o
);
  import spg_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [DW-1:0]    den_q, rem_q;
  logic [QUO_W-1:0] quo_q;
  logic             ovf_q;
  logic [DW:0]      trial, diff;
  logic             ge;

  // Shift in the next dividend bit and subtract when the divisor fits.
  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    ge    = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      done_o <= !start_i && busy_q && (cnt_q == CNT_W'(NUM_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        num_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        quo_q  <= '0;
        ovf_q  <= 1'b0;
      end else if (busy_q) begin
        num_q <= {num_q[NUM_W-2:0], 1'b0};
        rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quo_q <= {quo_q[QUO_W-2:0], ge};
        ovf_q <= ovf_q | quo_q[QUO_W-1];
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign quo_o = quo_q;
  assign ovf_o = ovf_q;

endmodule

`default_nettype wire

FILE: src/spiral_point_generator.sv
// Work per accepted word at defaults: 14 reduction steps, 1 to 4 quadrant steps, two
// CORDIC passes, a division and the sequencing steps; no division when the magnitude is
// zero. The input is not ready until the point word is registered, and the output step
// waits while an earlier point word is still held. A word past the count gives no point.
// Reset loads the register defaults and clears angle, radius and the emitted count.
// ----------------------------------------------------------------------------
// spiral_point_generator
// Emits equally spaced points of an Archimedean spiral using a shared CORDIC,
// a shared divider and one shared 32x32 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module spiral_point_generator #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 18
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_we_i,
  input  wire spg_pkg::cfg_idx_e   cfg_idx_i,
  input  wire  [31:0]              cfg_data_i,
  spg_in_if.sink                   in_i,
  spg_out_if.source                out_o
);
  import spg_pkg::*;

  localparam int DIV_W = (FRAC_BITS + 32 > 44) ? FRAC_BITS + 32 : 44;
  localparam logic [63:0] TwoPiRnd =
    (TWO_PI_Q60 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  // Angle reduction: compare and subtract against shifted multiples of 2*pi.
  localparam int MOD_W     = 32 + RED_EXTRA;
  localparam int MOD_STEPS = 30 - FRAC_BITS;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);
  localparam logic [MOD_W-1:0] TwoPiTop = MOD_W'(TwoPiRnd << (MOD_STEPS - 1));

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_QUAD, S_ROT, S_MULX, S_MULY, S_VSTART, S_VEC,
    S_MAGH, S_MAGL, S_MAGS, S_DSTART, S_DIV, S_RAD, S_RADS, S_OUT
  } state_e;

  state_e state_q;

  // Configuration and spiral state.
  logic [31:0] growth_q, start_q, spacing_q;
  logic [15:0] count_q;
  logic [31:0] angle_q, radius_q;
  logic [15:0] emitted_q;

  // Working registers.
  logic [MOD_W-1:0]           mod_rem_q, mod_den_q;
  logic [MOD_CNT_W-1:0]       mod_cnt_q;
  logic [32:0]                quad_z_q;
  logic [1:0]                 quad_q;
  logic signed [CORDIC_W-1:0] cos_q, sin_q;
  logic [41:0]                ux_q;
  logic [42:0]                mag_q;
  logic [63:0]                prod_q;
  logic [31:0]                px_q, py_q;

  // Output word register.
  logic        out_valid_q;
  logic [31:0] out_x_q, out_y_q;
  logic [15:0] out_idx_q;
  logic        out_last_q;

  // Unit connections.
  logic                       cor_start, cor_vector, cor_done;
  logic signed [CORDIC_W-1:0] cor_x_in, cor_y_in, cor_z_in, cor_x, cor_y;
  logic                       div_start, div_done, div_ovf;
  logic [NUM_W-1:0]           div_num;
  logic [DIV_W-1:0]           div_den;
  logic [QUO_W-1:0]           div_quo;
  logic [31:0]                mul_a, mul_b;

  logic        in_fire, restart_eff;
  logic [31:0] angle_eff;
  logic [15:0] emitted_eff;
  logic        quad_more;

  function automatic logic [31:0] abs32(input logic signed [CORDIC_W-1:0] v);
    return 32'(v[CORDIC_W-1] ? -v : v);
  endfunction

  // Radius times trig magnitude, back to Q16.16 with sign and saturation.
  function automatic logic [31:0] scale(input logic [63:0] p, input logic neg);
    logic [33:0] m;
    m = 34'(p >> 30);
    if (neg) begin
      return (m > 34'h080000000) ? 32'h80000000 : 32'(32'd0 - m[31:0]);
    end
    return (m > 34'h07FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
  endfunction

  assign in_fire     = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign restart_eff = in_i.restart;
  assign angle_eff   = restart_eff ? 32'd0 : angle_q;
  assign emitted_eff = restart_eff ? 16'd0 : emitted_q;
  assign quad_more   = (quad_z_q >= 33'(HALF_PI_Q30)) && (quad_q != 2'd3);

  // CORDIC request: rotation after quadrant reduction, vectoring for |(a, r)|.
  always_comb begin
    cor_start  = ((state_q == S_QUAD) && !quad_more) || (state_q == S_VSTART);
    cor_vector = (state_q == S_VSTART);
    if (cor_vector) begin
      cor_x_in = $signed(CORDIC_W'({growth_q, 8'd0}));
      cor_y_in = $signed(CORDIC_W'({radius_q, 8'd0}));
      cor_z_in = '0;
    end else begin
      cor_x_in = $signed(CORDIC_W'(CORDIC_GAIN_Q30));
      cor_y_in = '0;
      cor_z_in = $signed(CORDIC_W'(quad_z_q));
    end
  end

  // Divider request: the step division, only for a nonzero magnitude.
  always_comb begin
    div_start = (state_q == S_DSTART) && (mag_q != '0);
    div_num   = NUM_W'(spacing_q) << (FRAC_BITS + MAG_GUARD);
    div_den   = DIV_W'(mag_q);
  end

  // Shared multiplier operand selection.
  always_comb begin
    case (state_q)
      S_MULX: begin
        mul_a = radius_q;
        mul_b = abs32(cos_q);
      end
      S_MULY: begin
        mul_a = radius_q;
        mul_b = abs32(sin_q);
      end
      S_MAGH: begin
        mul_a = {6'd0, ux_q[41:16]};
        mul_b = {2'd0, CORDIC_GAIN_Q30};
      end
      S_MAGL: begin
        mul_a = {16'd0, ux_q[15:0]};
        mul_b = {2'd0, CORDIC_GAIN_Q30};
      end
      S_RAD: begin
        mul_a = growth_q;
        mul_b = angle_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  spg_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .vector_i(cor_vector),
    .x_i     (cor_x_in),
    .y_i     (cor_y_in),
    .z_i     (cor_z_in),
    .done_o  (cor_done),
    .x_o     (cor_x),
    .y_o     (cor_y)
  );

  spg_divider #(
    .DW(DIV_W)
  ) u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo),
    .ovf_o  (div_ovf)
  );

  // Sequencer, spiral state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [31:0]      step;
    logic [32:0]      asum;
    logic [63:0]      rp;
    logic [31:0]      rsat;
    logic [32:0]      rsum;
    logic [MOD_W-1:0] mrem;
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      growth_q    <= 32'd65536;
      start_q     <= 32'd0;
      spacing_q   <= 32'd65536;
      count_q     <= 16'd0;
      angle_q     <= 32'd0;
      radius_q    <= 32'd0;
      emitted_q   <= 16'd0;
      mod_rem_q   <= '0;
      mod_den_q   <= '0;
      mod_cnt_q   <= '0;
      quad_z_q    <= '0;
      quad_q      <= '0;
      cos_q       <= '0;
      sin_q       <= '0;
      ux_q        <= '0;
      mag_q       <= '0;
      prod_q      <= '0;
      px_q        <= '0;
      py_q        <= '0;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_idx_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      step = div_ovf ? 32'hFFFFFFFF : div_quo;
      asum = {1'b0, angle_q} + {1'b0, step};
      rp   = prod_q >> FRAC_BITS;
      rsat = (|rp[63:32]) ? 32'hFFFFFFFF : rp[31:0];
      rsum = {1'b0, rsat} + {1'b0, start_q};
      mrem = (mod_rem_q >= mod_den_q) ? mod_rem_q - mod_den_q : mod_rem_q;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GROWTH:  growth_q  <= cfg_data_i;
          CFG_START:   start_q   <= cfg_data_i;
          CFG_SPACING: spacing_q <= cfg_data_i;
          CFG_COUNT:   count_q   <= cfg_data_i[15:0];
          default:     ;
        endcase
      end

      // The output step reloads the word itself when it moves on.
      if (out_o.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (restart_eff) begin
              angle_q   <= 32'd0;
              radius_q  <= start_q;
              emitted_q <= 16'd0;
            end
            if (emitted_eff < count_q) begin
              mod_rem_q <= MOD_W'(angle_eff) << RED_EXTRA;
              mod_den_q <= TwoPiTop;
              mod_cnt_q <= '0;
              state_q   <= S_MOD;
            end
          end
        end
        S_MOD: begin
          mod_rem_q <= mrem;
          mod_den_q <= mod_den_q >> 1;
          mod_cnt_q <= mod_cnt_q + 1'b1;
          if (mod_cnt_q == MOD_CNT_W'(MOD_STEPS - 1)) begin
            quad_z_q <= 33'(mrem >> (FRAC_BITS + RED_EXTRA - 30));
            quad_q   <= 2'd0;
            state_q  <= S_QUAD;
          end
        end
        S_QUAD: begin
          if (quad_more) begin
            quad_z_q <= quad_z_q - 33'(HALF_PI_Q30);
            quad_q   <= quad_q + 2'd1;
          end else begin
            state_q <= S_ROT;
          end
        end
        S_ROT: begin
          if (cor_done) begin
            case (quad_q)
              2'd0: begin
                cos_q <= cor_x;
                sin_q <= cor_y;
              end
              2'd1: begin
                cos_q <= -cor_y;
                sin_q <= cor_x;
              end
              2'd2: begin
                cos_q <= -cor_x;
                sin_q <= -cor_y;
              end
              default: begin
                cos_q <= cor_y;
                sin_q <= -cor_x;
              end
            endcase
            state_q <= S_MULX;
          end
        end
        S_MULX: begin
          prod_q  <= mul_a * mul_b;
          state_q <= S_MULY;
        end
        S_MULY: begin
          px_q    <= scale(prod_q, cos_q[CORDIC_W-1]);
          prod_q  <= mul_a * mul_b;
          state_q <= S_VSTART;
        end
        S_VSTART: begin
          py_q    <= scale(prod_q, sin_q[CORDIC_W-1]);
          state_q <= S_VEC;
        end
        S_VEC: begin
          if (cor_done) begin
            ux_q    <= cor_x[CORDIC_W-1] ? 42'd0 : cor_x[41:0];
            state_q <= S_MAGH;
          end
        end
        S_MAGH: begin
          prod_q  <= mul_a * mul_b;
          state_q <= S_MAGL;
        end
        S_MAGL: begin
          mag_q   <= 43'(prod_q >> 14);
          prod_q  <= mul_a * mul_b;
          state_q <= S_MAGS;
        end
        S_MAGS: begin
          mag_q   <= mag_q + 43'(prod_q >> 30);
          state_q <= S_DSTART;
        end
        S_DSTART: begin
          if (mag_q == '0) begin
            angle_q <= 32'hFFFFFFFF;
            state_q <= S_RAD;
          end else begin
            state_q <= S_DIV;
          end
          // A zero divisor never starts the divider; see the request logic.
        end
        S_DIV: begin
          if (div_done) begin
            angle_q <= asum[32] ? 32'hFFFFFFFF : asum[31:0];
            state_q <= S_RAD;
          end
        end
        S_RAD: begin
          prod_q  <= mul_a * mul_b;
          state_q <= S_RADS;
        end
        S_RADS: begin
          radius_q <= rsum[32] ? 32'hFFFFFFFF : rsum[31:0];
          state_q  <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_x_q     <= px_q;
            out_y_q     <= py_q;
            out_idx_q   <= emitted_q;
            out_last_q  <= ({1'b0, emitted_q} + 17'd1) == {1'b0, count_q};
            emitted_q   <= emitted_q + 16'd1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.point_x     = out_x_q;
  assign out_o.point_y     = out_y_q;
  assign out_o.point_index = out_idx_q;
  assign out_o.last_point  = out_last_q;

`ifndef SYNTH
  // A new point word only appears as the sequencer finishes a point.
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(state_q == S_OUT))
    else $error("point word raised outside the output step");

  // The CORDIC unit only reports back while the sequencer waits on it.
  a_cordic_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_done |-> (state_q == S_ROT || state_q == S_VEC))
    else $error("CORDIC finished outside a CORDIC wait step");

  // The divider only reports back while the sequencer waits on it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divider wait step");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the spiral point generator. Restart words are
// driven in bursts, point words are taken with a random stall pattern, and
// every point is compared with a fixed-point model of the spiral kept here.
// ----------------------------------------------------------------------------
module tb_top;
  import spg_pkg::*;

  localparam int FRAC     = 16;
  localparam int STEPS    = 18;
  localparam int IDLE_GAP = 300;
  localparam int WD_LIMIT = 20000;
  localparam int N_ITEMS  = 850;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] index;
    logic        last;
  } point_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  cfg_idx_e    cfg_idx_i;
  logic [31:0] cfg_data_i;

  spg_in_if  in_if ();
  spg_out_if out_if ();

  spiral_point_generator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Arctangent of 2^-i in Q30 for the first steps.
  localparam longint ATAN_Q30 [10] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149
  };

  // Model registers and spiral state.
  logic [31:0] m_growth, m_start, m_spacing, m_angle, m_radius;
  logic [15:0] m_count, m_emitted;

  bit     restart_queue [$];
  point_t point_queue [$];
  int     errors, items_sent, points_seen, phases;
  int     gap, burst, stall_mode_cnt, idle_cycles;
  bit     always_ready;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Sine and cosine in Q30 of a Q16.16 angle.
  function automatic void spiral_trig(input logic [31:0] th, output longint cs,
                                      output longint sn);
    longint unsigned tp, rem, r30, q;
    longint x, y, z, nx, dx, dy, at;
    tp  = (TWO_PI_Q60 + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
    rem = ({32'd0, th} << RED_EXTRA) % tp;
    r30 = rem >> (FRAC + RED_EXTRA - 30);
    q   = r30 / HALF_PI_Q30;
    if (q > 3) q = 3;
    z = longint'(r30 - q * HALF_PI_Q30);
    x = CORDIC_GAIN_Q30;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      at = (i < 10) ? ATAN_Q30[i] : (i <= 30 ? (longint'(1) << (30 - i)) : 0);
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        nx = x - dx; y = y + dy; z = z - at;
      end else begin
        nx = x + dx; y = y - dy; z = z + at;
      end
      x = nx;
    end
    case (q)
      0:       begin cs = x;  sn = y;  end
      1:       begin cs = -y; sn = x;  end
      2:       begin cs = -x; sn = -y; end
      default: begin cs = y;  sn = -x; end
    endcase
  endfunction

  // Radius times a Q30 trig value, saturated to a signed 32-bit word.
  function automatic logic [31:0] scale_coord(input logic [31:0] r, input longint c);
    longint unsigned m, p;
    m = (c < 0) ? longint'(-c) : longint'(c);
    p = ({32'd0, r} * m) >> 30;
    if (c < 0) begin
      if (p > 64'h8000_0000) p = 64'h8000_0000;
      return 32'd0 - p[31:0];
    end
    if (p > 64'h7FFF_FFFF) p = 64'h7FFF_FFFF;
    return p[31:0];
  endfunction

  // sqrt(a^2 + r^2) with FRAC+8 fraction bits by CORDIC vectoring.
  function automatic longint unsigned arc_norm(input logic [31:0] a, input logic [31:0] r);
    longint x, y, nx, dx, dy;
    longint unsigned ux;
    x = longint'({32'd0, a}) << MAG_GUARD;
    y = longint'({32'd0, r}) << MAG_GUARD;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        nx = x + dx; y = y - dy;
      end else begin
        nx = x - dx; y = y + dy;
      end
      x = nx;
    end
    ux = (x < 0) ? 0 : x;
    return (((ux >> 16) * CORDIC_GAIN_Q30) >> 14) + (((ux & 64'hFFFF) * CORDIC_GAIN_Q30) >> 30);
  endfunction

  // Advance the spiral for one accepted restart word.
  task automatic spiral_advance(input bit restart);
    longint cs, sn;
    longint unsigned mag, step, na, prod;
    point_t p;
    if (restart) begin
      m_angle = '0; m_radius = m_start; m_emitted = '0;
    end
    if (m_emitted >= m_count) return;
    spiral_trig(m_angle, cs, sn);
    p.x     = scale_coord(m_radius, cs);
    p.y     = scale_coord(m_radius, sn);
    p.index = m_emitted;
    p.last  = ({16'd0, m_emitted} + 32'd1 == {16'd0, m_count});
    point_queue.push_back(p);
    mag = arc_norm(m_growth, m_radius);
    if (mag == 0) begin
      m_angle = '1;
    end else begin
      step = ({32'd0, m_spacing} << (FRAC + MAG_GUARD)) / mag;
      if (step > 64'hFFFF_FFFF) step = 64'hFFFF_FFFF;
      na = {32'd0, m_angle} + step;
      m_angle = (na > 64'hFFFF_FFFF) ? '1 : na[31:0];
    end
    prod = ({32'd0, m_growth} * {32'd0, m_angle}) >> FRAC;
    if (prod > 64'hFFFF_FFFF) prod = 64'hFFFF_FFFF;
    prod = prod + m_start;
    m_radius = (prod > 64'hFFFF_FFFF) ? '1 : prod[31:0];
    m_emitted = m_emitted + 16'd1;
  endtask

  // Driver: restart words in bursts with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.restart <= 1'b0;
      gap   <= 0;
      burst <= 1;
    end else if (in_if.valid && !in_if.ready) begin
      // Hold the word until it is taken.
    end else if (gap > 0) begin
      in_if.valid <= 1'b0;
      gap <= gap - 1;
    end else if (restart_queue.size() > 0) begin
      in_if.valid   <= 1'b1;
      in_if.restart <= restart_queue.pop_front();
      if (burst <= 1) begin
        burst <= $urandom_range(1, 12);
        gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
      end else begin
        burst <= burst - 1;
      end
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // Receiver stall pattern: stretches of full readiness and of random stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready   <= 1'b0;
      always_ready   <= 1'b1;
      stall_mode_cnt <= 0;
    end else begin
      if (stall_mode_cnt == 0) begin
        always_ready   <= $urandom_range(0, 1);
        stall_mode_cnt <= $urandom_range(50, 600);
      end else begin
        stall_mode_cnt <= stall_mode_cnt - 1;
      end
      out_if.ready <= always_ready ? 1'b1 : ($urandom_range(0, 99) < 40);
    end
  end

  // Predict on every accepted restart word.
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      spiral_advance(in_if.restart);
      items_sent <= items_sent + 1;
    end
  end

  // Check every accepted point word against the oldest prediction.
  always @(posedge clk_i) begin
    point_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.point_x, out_if.point_y, out_if.point_index, out_if.last_point};
      points_seen <= points_seen + 1;
      if (point_queue.size() == 0) begin
        $display("%0t: unexpected point x=%h y=%h index=%0d last=%0d", $time,
                 got.x, got.y, got.index, got.last);
        errors <= errors + 1;
      end else begin
        want = point_queue.pop_front();
        if (got !== want) begin
          $display("%0t: point mismatch expected x=%h y=%h index=%0d last=%0d", $time,
                   want.x, want.y, want.index, want.last);
          $display("%0t:                  actual x=%h y=%h index=%0d last=%0d", $time,
                   got.x, got.y, got.index, got.last);
          errors <= errors + 1;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word or register write.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Register write; the model copy is updated as the write is driven.
  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_GROWTH:  m_growth  = data;
      CFG_START:   m_start   = data;
      CFG_SPACING: m_spacing = data;
      CFG_COUNT:   m_count   = data[15:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_spiral(input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] s, input logic [15:0] n);
    write_reg(CFG_GROWTH, a);
    write_reg(CFG_START, b);
    write_reg(CFG_SPACING, s);
    write_reg(CFG_COUNT, {16'd0, n});
    phases++;
  endtask

  // Queue a restart followed by plain words.
  task automatic queue_run(input int n);
    restart_queue.push_back(1'b1);
    for (int i = 1; i < n; i++) restart_queue.push_back(1'b0);
  endtask

  // Wait until nothing is pending or predicted, let the block settle, and
  // wait once more for a word that was taken during the settling time.
  task automatic wait_idle();
    while (restart_queue.size() > 0 || in_if.valid || point_queue.size() > 0)
      @(posedge clk_i);
    repeat (IDLE_GAP) @(posedge clk_i);
    while (restart_queue.size() > 0 || in_if.valid || point_queue.size() > 0)
      @(posedge clk_i);
  endtask

  // Pick a value mixing small, typical and full-range operands.
  function automatic logic [31:0] pick_q16();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 32'h0004_0000);
      1:       return $urandom_range(0, 32'h0100_0000);
      2:       return $urandom;
      default: return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'd0;
    endcase
  endfunction

  // Sequencer: directed phases, then random phases.
  initial begin
    int n, len;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_idx_i = CFG_GROWTH; cfg_data_i = '0;
    in_if.valid = 1'b0; in_if.restart = 1'b0; out_if.ready = 1'b0;
    errors = 0; items_sent = 0; points_seen = 0; phases = 0; idle_cycles = 0;
    m_growth = 32'h0001_0000; m_start = '0; m_spacing = 32'h0001_0000; m_count = '0;
    m_angle = '0; m_radius = '0; m_emitted = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults with a zero count: words give no points.
    restart_queue.push_back(1'b0);
    restart_queue.push_back(1'b1);
    wait_idle();
    // Default spiral, run past the count to see the stop.
    set_spiral(32'h0001_0000, 32'd0, 32'h0001_0000, 16'd5);
    queue_run(7);
    wait_idle();
    // Zero growth and zero start radius: the angle saturates at once.
    set_spiral(32'd0, 32'd0, 32'h0001_0000, 16'd3);
    queue_run(3);
    wait_idle();
    // Largest operands everywhere.
    set_spiral(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    queue_run(3);
    wait_idle();
    // Tiny and zero spacing.
    set_spiral(32'h0000_8000, 32'h0002_0000, 32'd1, 16'd2);
    queue_run(2);
    wait_idle();
    set_spiral(32'h0001_0000, 32'h0003_0000, 32'd0, 16'd3);
    queue_run(3);
    wait_idle();

    // Random phases: mostly clean runs with occasional restarts mid-run.
    while (items_sent < N_ITEMS) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 80);
      set_spiral(pick_q16(), pick_q16(), ($urandom_range(0, 7) == 0) ? $urandom :
                 $urandom_range(1, 32'h0004_0000), n[15:0]);
      len = $urandom_range(20, 90);
      for (int i = 0; i < len; i++)
        restart_queue.push_back(i == 0 || $urandom_range(0, 99) < 4);
      wait_idle();
    end

    $display("Covered %0d configuration phases, %0d restart words and %0d points.",
             phases, items_sent, points_seen);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
